### hdl/vrs_pkg.sv
// vrs_pkg: shared types, constants and helpers for the verlet rope step core
// used by vrs_div, vrs_sqrt and verlet_rope_step_core; depends on nothing
`timescale 1ns / 1ps

package vrs_pkg;

  localparam int MAX_POINTS   = 32;
  localparam int IDX_W        = $clog2(MAX_POINTS);
  localparam int CNT_W        = $clog2(MAX_POINTS + 1);
  localparam int RELAX_PASSES = 5;
  localparam int PASS_W       = (RELAX_PASSES > 1) ? $clog2(RELAX_PASSES) : 1;

  // stream payload widths
  localparam int S_DATA_W = 88;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 128;
  localparam int M_USER_W = 1;
  localparam int CFG_IDX_W = 3;

  // divider and root widths
  localparam int DIV_W      = 51;
  localparam int DEN_W      = 34;
  localparam int LINK_QBITS = 20;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int SQ_W       = 63;
  localparam int ROOT_W     = 32;

  // request codes
  localparam logic [2:0] REQ_LAYOUT = 3'd0;
  localparam logic [2:0] REQ_STEP   = 3'd1;
  localparam logic [2:0] REQ_PUSH   = 3'd2;
  localparam logic [2:0] REQ_SET    = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 3'd5;

  localparam logic [17:0] RST_LINK_LEN = 18'd5120;
  localparam logic [15:0] RST_DAMPING  = 16'd32440;
  localparam logic [5:0]  RST_POINTS   = 6'd16;
  localparam logic [15:0] RST_GRAVITY  = 16'd980;

  localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

  typedef struct packed {
    logic             start;
    logic             full;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LAYOUT,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_INT_X,
    ST_INT_Y,
    ST_INT_WR,
    ST_PIN,
    ST_RL_A,
    ST_RL_B,
    ST_RL_SQX,
    ST_RL_SQY,
    ST_RL_SQS,
    ST_RL_ROOT,
    ST_RL_CHK,
    ST_RL_DXS,
    ST_RL_DXW,
    ST_RL_MULY,
    ST_RL_DYS,
    ST_RL_DYW,
    ST_RL_WR0,
    ST_RL_WR1,
    ST_RL_NEXT,
    ST_RD_XS,
    ST_RD_XW,
    ST_RD_YS,
    ST_RD_YW,
    ST_FIN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/vrs_div.sv
// vrs_div: restoring divider, one quotient bit per cycle
// link mode runs LINK_QBITS steps, full mode DIV_W steps; uses vrs_pkg
`timescale 1ns / 1ps

module vrs_div (
  input  logic                    clk,
  input  logic                    rst,
  input  vrs_pkg::div_req_t       req,
  output logic                    done,
  output logic [vrs_pkg::DIV_W-1:0] quot
);
  import vrs_pkg::*;

  logic                 busy;
  logic                 full;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     dv;
  logic [DIV_W-1:0]     dq;
  logic [DEN_W:0]       shifted;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign shifted = {rem, dq[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dv};
  assign diff    = shifted - {1'b0, dv};
  assign quot    = full ? dq : {{(DIV_W-LINK_QBITS){1'b0}}, dq[LINK_QBITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      full <= req.full;
      dv   <= req.divisor;
      if (req.full) begin
        rem <= '0;
        dq  <= req.dividend;
        cnt <= DIV_CNT_W'(DIV_W);
      end else begin
        // upper dividend bits stay below the divisor in link mode
        rem <= DEN_W'(req.dividend[DIV_W-1:LINK_QBITS]);
        dq  <= {req.dividend[LINK_QBITS-1:0], {(DIV_W-LINK_QBITS){1'b0}}};
        cnt <= DIV_CNT_W'(LINK_QBITS);
      end
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      dq  <= {dq[DIV_W-2:0], ge};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

endmodule

### hdl/vrs_sqrt.sv
// vrs_sqrt: bit-pair integer square root, one result bit per cycle
// floor root of a 63-bit radicand; uses vrs_pkg
`timescale 1ns / 1ps

module vrs_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vrs_pkg::SQ_W-1:0]   radicand,
  output logic                       done,
  output logic [vrs_pkg::ROOT_W-1:0] root
);
  import vrs_pkg::*;

  logic            busy;
  logic [SQ_W-1:0] x;
  logic [SQ_W-1:0] r;
  logic [SQ_W-1:0] b;
  logic [SQ_W:0]   rb;
  logic            ge;

  assign rb   = {1'b0, r} + {1'b0, b};
  assign ge   = {1'b0, x} >= rb;
  assign root = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && b[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= radicand;
      r <= '0;
      b <= {1'b1, {(SQ_W-1){1'b0}}};
    end else if (busy) begin
      if (ge) begin
        x <= x - rb[SQ_W-1:0];
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

### hdl/verlet_rope_step_core.sv
// verlet_rope_step_core: rope of point masses, layout, verlet step with link relaxation,
// push, set and read; depends on vrs_pkg, vrs_div and vrs_sqrt
// read of a valid index with nonzero time_step runs two full-width divides; step relaxes
//   all n-1 links in each of 5 passes, with a root and two link-mode divides per link
//   (a link with coincident ends skips the divides)
// flow: one beat at a time, next beat taken once the previous one reaches the output reg
// reset: synchronous, clears control, registers to defaults and all point positions to zero
`timescale 1ns / 1ps

module verlet_rope_step_core (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // point_index[4:0], value_x[36:5], value_y[68:37], time_step[84:69], zero pad
  input  logic [vrs_pkg::S_DATA_W-1:0]    s_tdata,
  // req_type[2:0]
  input  logic [vrs_pkg::S_USER_W-1:0]    s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96]
  output logic [vrs_pkg::M_DATA_W-1:0]    m_tdata,
  // index_ok[0]
  output logic [vrs_pkg::M_USER_W-1:0]    m_tuser,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import vrs_pkg::*;

  // configuration registers
  logic signed [31:0] anchor_x;
  logic signed [31:0] anchor_y;
  logic [17:0]        link_length;
  logic [15:0]        damping_factor;
  logic [5:0]         points_in_use;
  logic [15:0]        gravity_accel;

  // point state
  logic signed [31:0] cur_x  [MAX_POINTS];
  logic signed [31:0] cur_y  [MAX_POINTS];
  logic signed [31:0] prev_x [MAX_POINTS];
  logic signed [31:0] prev_y [MAX_POINTS];

  state_t state, state_next;

  // latched request
  logic [2:0]         rq_type;
  logic [IDX_W-1:0]   rq_idx;
  logic signed [31:0] rq_vx;
  logic signed [31:0] rq_vy;
  logic [15:0]        rq_dt;

  // sequencer working registers
  logic [IDX_W-1:0]   ix;
  logic [PASS_W-1:0]  pass;
  logic signed [39:0] yacc;
  logic [24:0]        grav;
  logic signed [32:0] ex, ey;
  logic signed [31:0] lx, ly, rx, ry;
  logic               kshift;
  logic [SQ_W-1:0]    sq_acc;
  logic [32:0]        lspan;
  logic signed [34:0] ox_x, ox_y;
  logic signed [39:0] vxr;

  // result registers
  logic signed [31:0] res_px, res_py, res_vx, res_vy;
  logic               res_ok;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // shared units
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic               sq_start;
  logic               sq_done;
  logic [ROOT_W-1:0]  sq_root;

  // combinational helpers
  logic [CNT_W-1:0]   n_pts;
  logic [IDX_W-1:0]   rd_addr;
  logic signed [31:0] rd_cx, rd_cy, rd_px, rd_py;
  logic signed [32:0] diff_x, diff_y;
  logic [32:0]        ex_abs, ey_abs;
  logic               kneed;
  logic [30:0]        exk, eyk;
  logic signed [65:0] rnd_p;
  logic signed [34:0] oxm_x, oxm_y;
  logic               idx_in;
  logic               last_link;

  function automatic logic signed [31:0] sat_quot(input logic [DIV_W-1:0] q,
                                                   input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (q > DIV_W'(33'h080000000)) r = 32'sh80000000;
      else r = 32'(-q);
    end else begin
      if (q > DIV_W'(32'h7fffffff)) r = 32'sh7fffffff;
      else r = q[31:0];
    end
    return r;
  endfunction

  // chain size clamp
  always_comb begin
    if (points_in_use < CNT_W'(2)) n_pts = CNT_W'(2);
    else if (points_in_use > 6'(MAX_POINTS)) n_pts = CNT_W'(MAX_POINTS);
    else n_pts = CNT_W'(points_in_use);
  end

  // single read address per array
  always_comb begin
    if (state == ST_EXEC) rd_addr = rq_idx;
    else if (state == ST_RL_B) rd_addr = ix + IDX_W'(1);
    else rd_addr = ix;
  end

  assign rd_cx  = cur_x[rd_addr];
  assign rd_cy  = cur_y[rd_addr];
  assign rd_px  = prev_x[rd_addr];
  assign rd_py  = prev_y[rd_addr];
  assign diff_x = 33'(rd_cx) - 33'(rd_px);
  assign diff_y = 33'(rd_cy) - 33'(rd_py);

  assign ex_abs = ex[32] ? 33'(-ex) : 33'(ex);
  assign ey_abs = ey[32] ? 33'(-ey) : 33'(ey);
  // both halved once when either magnitude reaches 2^31
  assign kneed  = ex_abs[32] | ex_abs[31] | ey_abs[32] | ey_abs[31];
  assign exk    = kneed ? ex_abs[31:1] : ex_abs[30:0];
  assign eyk    = kneed ? ey_abs[31:1] : ey_abs[30:0];

  // damped velocity, floor of (d * damping + half) / 2^15
  assign rnd_p  = (mul_p + 66'sd16384) >>> 15;

  // link correction: trunc(|d|*len / 2*span) - trunc(|d|/2), sign restored later
  assign oxm_x = $signed({15'b0, div_quot[LINK_QBITS-1:0]}) - $signed({3'b0, ex_abs[32:1]});
  assign oxm_y = $signed({15'b0, div_quot[LINK_QBITS-1:0]}) - $signed({3'b0, ey_abs[32:1]});

  assign idx_in    = {1'b0, rq_idx} < n_pts;
  assign last_link = (CNT_W'(ix) + CNT_W'(2)) == n_pts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  vrs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  vrs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_acc + mul_p[SQ_W-1:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, multiplier operands and unit starts
  always_comb begin
    state_next       = state;
    s_tready         = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    sq_start         = 1'b0;
    div_req.start    = 1'b0;
    div_req.full     = 1'b0;
    div_req.dividend = mul_p[DIV_W-1:0];
    div_req.divisor  = {lspan, 1'b0};
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (rq_type) inside
          REQ_LAYOUT: state_next = ST_LAYOUT;
          REQ_STEP:   state_next = ST_G1;
          REQ_READ: begin
            if (idx_in && rq_dt != 16'd0) state_next = ST_RD_XS;
            else state_next = ST_FIN;
          end
          default:    state_next = ST_FIN;
        endcase
      end
      ST_LAYOUT: begin
        if ((CNT_W'(ix) + CNT_W'(1)) == n_pts) state_next = ST_FIN;
      end
      ST_G1: begin
        mul_a      = {17'b0, gravity_accel};
        mul_b      = {17'b0, rq_dt};
        state_next = ST_G2;
      end
      ST_G2: begin
        mul_a      = {1'b0, mul_p[31:0]};
        mul_b      = {17'b0, rq_dt};
        state_next = ST_G3;
      end
      ST_G3: state_next = ST_INT_X;
      ST_INT_X: begin
        mul_a      = diff_x;
        mul_b      = {17'b0, damping_factor};
        state_next = ST_INT_Y;
      end
      ST_INT_Y: begin
        mul_a      = diff_y;
        mul_b      = {17'b0, damping_factor};
        state_next = ST_INT_WR;
      end
      ST_INT_WR: begin
        if ((CNT_W'(ix) + CNT_W'(1)) == n_pts) state_next = ST_PIN;
        else state_next = ST_INT_X;
      end
      ST_PIN:    state_next = ST_RL_A;
      ST_RL_A:   state_next = ST_RL_B;
      ST_RL_B:   state_next = ST_RL_SQX;
      ST_RL_SQX: begin
        mul_a      = {2'b0, exk};
        mul_b      = {2'b0, exk};
        state_next = ST_RL_SQY;
      end
      ST_RL_SQY: begin
        mul_a      = {2'b0, eyk};
        mul_b      = {2'b0, eyk};
        state_next = ST_RL_SQS;
      end
      ST_RL_SQS: begin
        sq_start   = 1'b1;
        state_next = ST_RL_ROOT;
      end
      ST_RL_ROOT: begin
        if (sq_done) state_next = ST_RL_CHK;
      end
      ST_RL_CHK: begin
        mul_a = ex_abs;
        mul_b = {15'b0, link_length};
        // coincident link ends: leave the link alone
        if (lspan == 33'd0) state_next = ST_RL_NEXT;
        else state_next = ST_RL_DXS;
      end
      ST_RL_DXS: begin
        div_req.start = 1'b1;
        state_next    = ST_RL_DXW;
      end
      ST_RL_DXW: begin
        if (div_done) state_next = ST_RL_MULY;
      end
      ST_RL_MULY: begin
        mul_a      = ey_abs;
        mul_b      = {15'b0, link_length};
        state_next = ST_RL_DYS;
      end
      ST_RL_DYS: begin
        div_req.start = 1'b1;
        state_next    = ST_RL_DYW;
      end
      ST_RL_DYW: begin
        if (div_done) state_next = ST_RL_WR0;
      end
      ST_RL_WR0: state_next = ST_RL_WR1;
      ST_RL_WR1: state_next = ST_RL_NEXT;
      ST_RL_NEXT: begin
        if (last_link && pass == PASS_W'(RELAX_PASSES - 1)) state_next = ST_FIN;
        else state_next = ST_RL_A;
      end
      ST_RD_XS: begin
        div_req.start    = 1'b1;
        div_req.full     = 1'b1;
        div_req.dividend = {2'b0, ex_abs, 16'b0};
        div_req.divisor  = {18'b0, rq_dt};
        state_next       = ST_RD_XW;
      end
      ST_RD_XW: begin
        if (div_done) state_next = ST_RD_YS;
      end
      ST_RD_YS: begin
        div_req.start    = 1'b1;
        div_req.full     = 1'b1;
        div_req.dividend = {2'b0, ey_abs, 16'b0};
        div_req.divisor  = {18'b0, rq_dt};
        state_next       = ST_RD_YW;
      end
      ST_RD_YW: begin
        if (div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x       <= '0;
      anchor_y       <= '0;
      link_length    <= RST_LINK_LEN;
      damping_factor <= RST_DAMPING;
      points_in_use  <= RST_POINTS;
      gravity_accel  <= RST_GRAVITY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANCHOR_X: anchor_x       <= cfg_data;
        CFG_ANCHOR_Y: anchor_y       <= cfg_data;
        CFG_LINK_LEN: link_length    <= cfg_data[17:0];
        CFG_DAMPING:  damping_factor <= cfg_data[15:0];
        CFG_POINTS:   points_in_use  <= cfg_data[5:0];
        CFG_GRAVITY:  gravity_accel  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // point arrays
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        cur_x[i]  <= '0;
        cur_y[i]  <= '0;
        prev_x[i] <= '0;
        prev_y[i] <= '0;
      end
    end else begin
      case (state)
        ST_EXEC: begin
          if (rq_type == REQ_PUSH && rq_idx != '0 && idx_in) begin
            prev_x[rq_idx] <= sat32(40'(rd_px) - 40'(rq_vx));
            prev_y[rq_idx] <= sat32(40'(rd_py) - 40'(rq_vy));
          end
          if (rq_type == REQ_SET && idx_in) begin
            cur_x[rq_idx] <= rq_vx;
            cur_y[rq_idx] <= rq_vy;
          end
        end
        ST_LAYOUT: begin
          cur_x[ix]  <= anchor_x;
          prev_x[ix] <= anchor_x;
          cur_y[ix]  <= sat32(yacc);
          prev_y[ix] <= sat32(yacc);
        end
        ST_INT_WR: begin
          prev_x[ix] <= rd_cx;
          prev_y[ix] <= rd_cy;
          cur_x[ix]  <= sat32(40'(rd_cx) + vxr);
          cur_y[ix]  <= sat32(40'(rd_cy) + rnd_p[39:0] + $signed({15'b0, grav}));
        end
        ST_PIN: begin
          cur_x[0]  <= anchor_x;
          prev_x[0] <= anchor_x;
          cur_y[0]  <= anchor_y;
          prev_y[0] <= anchor_y;
        end
        ST_RL_WR0: begin
          // the anchored point never moves during relaxation
          if (ix != '0) begin
            cur_x[ix] <= sat32(40'(lx) - 40'(ox_x));
            cur_y[ix] <= sat32(40'(ly) - 40'(ox_y));
          end
        end
        ST_RL_WR1: begin
          cur_x[ix + IDX_W'(1)] <= sat32(40'(rx) + 40'(ox_x));
          cur_y[ix + IDX_W'(1)] <= sat32(40'(ry) + 40'(ox_y));
        end
        default: ;
      endcase
    end
  end

  // working registers and results
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          rq_type <= s_tuser;
          rq_idx  <= s_tdata[4:0];
          rq_vx   <= s_tdata[36:5];
          rq_vy   <= s_tdata[68:37];
          rq_dt   <= s_tdata[84:69];
        end
      end
      ST_EXEC: begin
        res_px <= '0;
        res_py <= '0;
        res_vx <= '0;
        res_vy <= '0;
        res_ok <= 1'b0;
        ix     <= '0;
        yacc   <= 40'(anchor_y);
        ex     <= diff_x;
        ey     <= diff_y;
        if (rq_type == REQ_PUSH && rq_idx != '0 && idx_in) res_ok <= 1'b1;
        if (rq_type == REQ_SET && idx_in) res_ok <= 1'b1;
        if (rq_type == REQ_READ && idx_in) begin
          res_px <= rd_cx;
          res_py <= rd_cy;
          res_ok <= 1'b1;
        end
      end
      ST_LAYOUT: begin
        yacc <= yacc + 40'(link_length);
        ix   <= ix + IDX_W'(1);
      end
      ST_G3: begin
        grav <= 25'((mul_p[48:0] + 49'd8388608) >> 24);
        ix   <= IDX_W'(1);
      end
      ST_INT_Y:  vxr <= rnd_p[39:0];
      ST_INT_WR: ix  <= ix + IDX_W'(1);
      ST_PIN: begin
        ix   <= '0;
        pass <= '0;
      end
      ST_RL_A: begin
        lx <= rd_cx;
        ly <= rd_cy;
      end
      ST_RL_B: begin
        rx <= rd_cx;
        ry <= rd_cy;
        ex <= 33'(rd_cx) - 33'(lx);
        ey <= 33'(rd_cy) - 33'(ly);
      end
      ST_RL_SQX: kshift <= kneed;
      ST_RL_SQY: sq_acc <= mul_p[SQ_W-1:0];
      ST_RL_ROOT: begin
        if (sq_done) lspan <= kshift ? {sq_root, 1'b0} : {1'b0, sq_root};
      end
      ST_RL_DXW: begin
        if (div_done) ox_x <= ex[32] ? -oxm_x : oxm_x;
      end
      ST_RL_DYW: begin
        if (div_done) ox_y <= ey[32] ? -oxm_y : oxm_y;
      end
      ST_RL_NEXT: begin
        if (last_link) begin
          ix   <= '0;
          pass <= pass + PASS_W'(1);
        end else begin
          ix <= ix + IDX_W'(1);
        end
      end
      ST_RD_XW: begin
        if (div_done) res_vx <= sat_quot(div_quot, ex[32]);
      end
      ST_RD_YW: begin
        if (div_done) res_vy <= sat_quot(div_quot, ey[32]);
      end
      default: ;
    endcase
  end

  // output register, free to take a new request while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_vy, res_vx, res_py, res_px};
      m_tuser <= res_ok;
    end
  end

endmodule

### hdl/vrs_checker.sv
// vrs_checker: port-level checks on the verlet rope step core
// bound to verlet_rope_step_core; no package dependency
`timescale 1ns / 1ps

module vrs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  // one request in flight: a taken beat closes the input side
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still ready right after a beat");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // reset leaves the core idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("core not idle after reset");

  // a result cannot appear in the cycle after a request is taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared without processing");

endmodule

bind verlet_rope_step_core vrs_checker u_vrs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
